// ===== src/bss_pkg.sv =====
// Shared types, character codes and reset values for the BASIC statement splitter.
package bss_pkg;

	// Character codes
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] STMT_MAX = 8'hFF;

	// REM recognizer stages
	typedef enum logic [2:0] {
		REM_SKIP,
		REM_R,
		REM_RE,
		REM_REM,
		REM_IDLE
	} rem_stage_t;

	// THEN recognizer stages
	typedef enum logic [2:0] {
		THEN_NONE,
		THEN_T,
		THEN_TH,
		THEN_THE,
		THEN_THEN
	} then_stage_t;

	// Per-line scanner state
	typedef struct packed {
		logic        quote_f;
		logic        comment_f;
		logic        then_f;
		rem_stage_t  rem_st;
		then_stage_t then_st;
		logic        prev_boundary;
		logic [7:0]  stmt_cnt;
	} scan_state_t;

	// One result transaction
	typedef struct packed {
		logic [7:0] char_out;
		logic       is_separator;
		logic [7:0] statement_number;
		logic       quoted;
		logic       comment_mode;
		logic       then_seen;
		logic       line_done;
	} scan_result_t;

	localparam scan_state_t STATE_RST = '{
		quote_f:       1'b0,
		comment_f:     1'b0,
		then_f:        1'b0,
		rem_st:        REM_SKIP,
		then_st:       THEN_NONE,
		prev_boundary: 1'b1,
		stmt_cnt:      8'd0
	};

	// Whitespace skipped before REM: tab through carriage return, and space
	function automatic logic is_white(input logic [7:0] c);
		is_white = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	endfunction

endpackage

// ===== src/bss_scan.sv =====
// Next-state and result logic for one character of the splitter.
module bss_scan
	import bss_pkg::*;
(
	input  scan_state_t  cur,
	input  logic [7:0]   ch,
	input  logic         eol,
	output scan_state_t  nxt,
	output scan_result_t res
);

	logic split;
	logic is_blank;

	assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);

	always_comb begin
		nxt   = cur;
		split = 1'b0;

		// quote tracking, frozen inside a comment
		if (ch == CH_QUOTE && !cur.comment_f) begin
			nxt.quote_f = !cur.quote_f;
		end

		// THEN recognizer
		case (cur.then_st)
			THEN_T:  nxt.then_st = (ch == CH_H) ? THEN_TH : THEN_NONE;
			THEN_TH: nxt.then_st = (ch == CH_E) ? THEN_THE : THEN_NONE;
			THEN_THE: begin
				if (ch == CH_N) begin
					if (eol) begin
						nxt.then_f  = 1'b1;
						nxt.then_st = THEN_NONE;
					end else begin
						nxt.then_st = THEN_THEN;
					end
				end else begin
					nxt.then_st = THEN_NONE;
				end
			end
			THEN_THEN: begin
				if (is_blank) begin
					nxt.then_f = 1'b1;
				end
				nxt.then_st = THEN_NONE;
			end
			default: begin
				nxt.then_st = THEN_NONE;
				if (ch == CH_T && !nxt.quote_f && !cur.comment_f && !cur.then_f
				    && cur.prev_boundary) begin
					nxt.then_st = THEN_T;
				end
			end
		endcase

		// colon split uses the updated quote and THEN flags
		split = (ch == CH_COLON) && !cur.comment_f && !nxt.quote_f && !nxt.then_f;

		if (split) begin
			if (cur.stmt_cnt != STMT_MAX) begin
				nxt.stmt_cnt = cur.stmt_cnt + 8'd1;
			end
			nxt.then_f        = 1'b0;
			nxt.then_st       = THEN_NONE;
			nxt.rem_st        = REM_SKIP;
			nxt.prev_boundary = 1'b0;
		end else begin
			// REM recognizer
			case (cur.rem_st)
				REM_SKIP: begin
					if (!is_white(ch)) begin
						nxt.rem_st = (ch == CH_R) ? REM_R : REM_IDLE;
					end
				end
				REM_R:  nxt.rem_st = (ch == CH_E) ? REM_RE : REM_IDLE;
				REM_RE: begin
					if (ch == CH_M) begin
						if (eol) begin
							nxt.comment_f = 1'b1;
							nxt.rem_st    = REM_IDLE;
						end else begin
							nxt.rem_st = REM_REM;
						end
					end else begin
						nxt.rem_st = REM_IDLE;
					end
				end
				REM_REM: begin
					if (ch == CH_SPACE) begin
						nxt.comment_f = 1'b1;
					end
					nxt.rem_st = REM_IDLE;
				end
				default: nxt.rem_st = REM_IDLE;
			endcase
			nxt.prev_boundary = is_blank;
		end

		// result reflects flags after this character
		res.char_out         = ch;
		res.is_separator     = split;
		res.statement_number = cur.stmt_cnt;
		res.quoted           = nxt.quote_f;
		res.comment_mode     = nxt.comment_f;
		res.then_seen        = nxt.then_f;
		res.line_done        = eol;

		// back to line-start values after the last character
		if (eol) begin
			nxt = STATE_RST;
		end
	end

endmodule

// ===== src/basic_statement_splitter_top.sv =====
// Top level of the BASIC statement splitter: input register, scanner and result register.
//
// Usage: one byte of a BASIC source line enters per input transaction on
// char_code, with end_of_line high on the last byte of the line. Each input
// transaction yields exactly one result transaction that echoes the byte and
// reports its separator mark, statement number and the quote, REM and THEN
// flags as they stand after that byte.
// Both channels use valid/stall; a transaction completes on a rising edge
// with valid high and stall low.
// Stages: a byte passes through two register stages, the input register,
// then the result register.
// Throughput: one byte per cycle while the output is not stalled; the scanner
// state is a handful of flags and an 8-bit counter, updated as the byte
// leaves the input register.
// Stall: while out_stall holds a waiting result, the input register still
// takes one more byte; in_stall rises only when both stages are full.
// Reset: arst_n clears both stages and returns the scanner to line start.
module basic_statement_splitter_top
	import bss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       end_of_line,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] char_out,
	output logic       is_separator,
	output logic [7:0] statement_number,
	output logic       quoted,
	output logic       comment_mode,
	output logic       then_seen,
	output logic       line_done
);

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         eol_s1;
	logic         valid_s2;
	scan_result_t res_s2;
	scan_state_t  state_q;
	scan_state_t  state_nxt;
	scan_result_t res_nxt;
	logic         load_s1;
	logic         adv;

	// handshake control
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;
	assign load_s1  = in_valid && !in_stall;

	// character scanner
	bss_scan u_scan (
		.cur (state_q),
		.ch  (char_s1),
		.eol (eol_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			char_s1 <= char_code;
			eol_s1  <= end_of_line;
		end
	end

	// result register and scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= STATE_RST;
		end else if (adv) begin
			valid_s2 <= 1'b1;
			state_q  <= state_nxt;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid        = valid_s2;
	assign char_out         = res_s2.char_out;
	assign is_separator     = res_s2.is_separator;
	assign statement_number = res_s2.statement_number;
	assign quoted           = res_s2.quoted;
	assign comment_mode     = res_s2.comment_mode;
	assign then_seen        = res_s2.then_seen;
	assign line_done        = res_s2.line_done;

	// a separator is always an unquoted colon outside comment and THEN
	a_sep_colon: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_separator) |->
		(char_out == CH_COLON && !quoted && !comment_mode && !then_seen))
		else $error("separator on a character that cannot split");

	// the last character of a line returns the scanner to line start
	a_eol_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && eol_s1) |=> (state_q == STATE_RST))
		else $error("scanner state not at line start after end of line");

	// input side stalls only when both stages hold data and output is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a full pipeline");

	// scanner state moves only when a character advances
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("scanner state changed without an advancing character");

	// a separating colon that does not end the line steps the statement counter by one below its maximum
	a_sep_count: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_nxt.is_separator && !eol_s1 && state_q.stmt_cnt != STMT_MAX) |=>
		(state_q.stmt_cnt == $past(state_q.stmt_cnt) + 8'd1))
		else $error("statement counter did not step on a separator");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the BASIC statement splitter: directed lines plus random lines.
`timescale 1ns / 1ps

module tb_top
	import bss_pkg::*;
();

	localparam int CLK_HALF    = 4;
	localparam int RESET_TICKS = 12;
	localparam int TOTAL_CHARS = 850;
	localparam int TAIL_TICKS  = 10;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] char_code = 8'd0;
	logic       end_of_line = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] char_out;
	logic       is_separator;
	logic [7:0] statement_number;
	logic       quoted;
	logic       comment_mode;
	logic       then_seen;
	logic       line_done;

	// Scanner state mirror
	logic        in_quote;
	logic        in_comment;
	logic        then_hit;
	rem_stage_t  rem_st;
	then_stage_t then_st;
	logic        after_blank;
	logic [7:0]  stmt_idx;

	scan_result_t pending_results[$];
	scan_result_t want_res;
	logic [7:0]   line_buf[$];

	int idle_pct = 0;
	int stall_pct = 0;
	int chars_sent = 0;
	int lines_sent = 0;
	int results_checked = 0;
	int mismatches = 0;

	basic_statement_splitter_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.char_code        (char_code),
		.end_of_line      (end_of_line),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.char_out         (char_out),
		.is_separator     (is_separator),
		.statement_number (statement_number),
		.quoted           (quoted),
		.comment_mode     (comment_mode),
		.then_seen        (then_seen),
		.line_done        (line_done)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Hard stop in case a handshake hangs
	initial begin
		#(2_000_000);
		$display("Some tests failed");
		$finish;
	end

	// Back to line-start values
	function automatic void line_start();
		in_quote    = 1'b0;
		in_comment  = 1'b0;
		then_hit    = 1'b0;
		rem_st      = REM_SKIP;
		then_st     = THEN_NONE;
		after_blank = 1'b1;
		stmt_idx    = 8'd0;
	endfunction

	// Expected result for one accepted character; advances the mirror state
	function automatic scan_result_t scan_char(input logic [7:0] c, input logic eol);
		scan_result_t r;
		logic         split;
		logic         blank;
		r.statement_number = stmt_idx;
		blank = (c == CH_SPACE) || (c == CH_TAB);

		if (c == CH_QUOTE && !in_comment)
			in_quote = ~in_quote;

		// THEN recognizer
		case (then_st)
			THEN_T:   then_st = (c == CH_H) ? THEN_TH : THEN_NONE;
			THEN_TH:  then_st = (c == CH_E) ? THEN_THE : THEN_NONE;
			THEN_THE: begin
				if (c == CH_N && eol) begin
					then_hit = 1'b1;
					then_st  = THEN_NONE;
				end else if (c == CH_N) begin
					then_st = THEN_THEN;
				end else begin
					then_st = THEN_NONE;
				end
			end
			THEN_THEN: begin
				if (blank)
					then_hit = 1'b1;
				then_st = THEN_NONE;
			end
			default: begin
				then_st = THEN_NONE;
				if (c == CH_T && !in_quote && !in_comment && !then_hit && after_blank)
					then_st = THEN_T;
			end
		endcase

		split = (c == CH_COLON) && !in_comment && !in_quote && !then_hit;

		if (split) begin
			if (stmt_idx != STMT_MAX)
				stmt_idx = stmt_idx + 8'd1;
			then_hit    = 1'b0;
			then_st     = THEN_NONE;
			rem_st      = REM_SKIP;
			after_blank = 1'b0;
		end else begin
			// REM recognizer, leading whitespace is 9..13 and space
			case (rem_st)
				REM_SKIP: begin
					if (!(c == CH_SPACE || (c >= 8'd9 && c <= 8'd13)))
						rem_st = (c == CH_R) ? REM_R : REM_IDLE;
				end
				REM_R:  rem_st = (c == CH_E) ? REM_RE : REM_IDLE;
				REM_RE: begin
					if (c == CH_M && eol) begin
						in_comment = 1'b1;
						rem_st     = REM_IDLE;
					end else if (c == CH_M) begin
						rem_st = REM_REM;
					end else begin
						rem_st = REM_IDLE;
					end
				end
				REM_REM: begin
					if (c == CH_SPACE)
						in_comment = 1'b1;
					rem_st = REM_IDLE;
				end
				default: rem_st = REM_IDLE;
			endcase
			after_blank = blank;
		end

		r.char_out     = c;
		r.is_separator = split;
		r.quoted       = in_quote;
		r.comment_mode = in_comment;
		r.then_seen    = then_hit;
		r.line_done    = eol;
		if (eol)
			line_start();
		return r;
	endfunction

	// One input transaction, with random idle cycles ahead of it
	task automatic send_char(input logic [7:0] c, input logic eol);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		char_code   <= c;
		end_of_line <= eol;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(scan_char(c, eol));
		chars_sent++;
		if (eol)
			lines_sent++;
	endtask

	// Sends line_buf as one line, end_of_line on its last byte
	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++)
			send_char(line_buf[i], i == line_buf.size() - 1);
	endtask

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endfunction

	task automatic send_text(input string s);
		line_buf.delete();
		push_text(s);
		send_line();
	endtask

	// Sender holds off until every predicted result is out
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [7:0] want_v, input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h, actual %0h", name, want_v, got_v);
			mismatches++;
		end
	endtask

	// Result checker and random receiver stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction, char_out %0h", char_out);
				mismatches++;
			end else begin
				want_res = pending_results.pop_front();
				check_field("char_out", want_res.char_out, char_out);
				check_field("is_separator", 8'(want_res.is_separator), 8'(is_separator));
				check_field("statement_number", want_res.statement_number, statement_number);
				check_field("quoted", 8'(want_res.quoted), 8'(quoted));
				check_field("comment_mode", 8'(want_res.comment_mode), 8'(comment_mode));
				check_field("then_seen", 8'(want_res.then_seen), 8'(then_seen));
				check_field("line_done", 8'(want_res.line_done), 8'(line_done));
				results_checked++;
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Colon inside quotes, separating colon, THEN right after a colon
	task automatic test_quoted_colon();
		send_text("\":\":THEN");
	endtask

	// Whitespace before REM, quote inside a comment, REM completed at line end
	task automatic test_rem_comment();
		send_text("\tREM :\"");
		send_text("REM");
	endtask

	// THEN at line start, tab delimiter, colon kept whole afterwards
	task automatic test_then_keyword();
		send_text("THEN\t:");
	endtask

	// Byte zero and 0xFF
	task automatic test_byte_extremes();
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b1);
	endtask

	// Enough separators to pin the statement number at its maximum
	task automatic test_counter_saturation();
		line_buf.delete();
		for (int i = 0; i < 258; i++)
			line_buf.push_back(CH_COLON);
		push_text("X");
		send_line();
		drain_results();
	endtask

	// Mostly token-built lines, some pure noise
	function automatic void build_random_line();
		int n_tok;
		line_buf.delete();
		if ($urandom_range(4) == 0) begin
			n_tok = $urandom_range(1, 8);
			for (int i = 0; i < n_tok; i++)
				line_buf.push_back(8'($urandom_range(255)));
			return;
		end
		n_tok = $urandom_range(1, 10);
		for (int i = 0; i < n_tok; i++) begin
			case ($urandom_range(15))
				0:  push_text("REM ");
				1:  push_text("REM");
				2:  push_text(" THEN ");
				3:  push_text("THEN");
				4:  push_text(":");
				5:  push_text("\"");
				6:  push_text(" ");
				7:  push_text("\t");
				8:  line_buf.push_back(8'($urandom_range(9, 13)));
				9: begin
					case ($urandom_range(4))
						0: push_text("T");
						1: push_text("TH");
						2: push_text("THE");
						3: push_text("R");
						default: push_text("RE");
					endcase
				end
				10: line_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
				11: line_buf.push_back(8'($urandom_range(255)));
				12: push_text("PRINT");
				13: push_text("IF X THEN ");
				14: push_text(":");
				default: push_text("REM\t");
			endcase
		end
	endfunction

	// One idle/stall mix, then a full drain
	task automatic test_random_lines(input int idle_p, input int stall_p, input int quota);
		int start_cnt;
		idle_pct  = idle_p;
		stall_pct = stall_p;
		start_cnt = chars_sent;
		while (chars_sent - start_cnt < quota) begin
			build_random_line();
			send_line();
		end
		drain_results();
	endtask

	initial begin
		int quota;
		line_start();
		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_quoted_colon();
		test_rem_comment();
		test_then_keyword();
		test_byte_extremes();
		drain_results();
		test_counter_saturation();

		quota = (TOTAL_CHARS - chars_sent) / 4;
		test_random_lines(0, 0, quota);
		test_random_lines(68, 0, quota);
		test_random_lines(0, 68, quota);
		test_random_lines(35, 35, quota);

		repeat (TAIL_TICKS) @(posedge clk);
		$display("Sent %0d characters in %0d lines under four idle/stall mixes",
			chars_sent, lines_sent);
		$display("Checked %0d result transactions, %0d field mismatches",
			results_checked, mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
